// ----- rtl/core/tes_pkg.sv -----
// ----------------------------------------------------------------------------
// tes_pkg
// Shared constants and types for the triangle element stiffness pipeline.
// ----------------------------------------------------------------------------
package tes_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int NUM_CORNERS = 3;
	localparam int NUM_K       = 6;

	typedef logic [1:0] corner_idx_t;

	// Corner pairs in result order: 00, 11, 22, 01, 12, 20
	localparam corner_idx_t PAIR_A [NUM_K] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2};
	localparam corner_idx_t PAIR_B [NUM_K] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd0};

	typedef struct packed {
		logic valid;
		logic degen;
	} ctl_t;

endpackage

// ----- rtl/core/tes_if.sv -----
// ----------------------------------------------------------------------------
// tes_if
// Valid/ready channels: triangle corners in, stiffness entries out.
// ----------------------------------------------------------------------------
interface tes_in_if #(
	parameter int COORD_WIDTH = 18
) ();
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] x0;
	logic signed [COORD_WIDTH-1:0] y0;
	logic signed [COORD_WIDTH-1:0] x1;
	logic signed [COORD_WIDTH-1:0] y1;
	logic signed [COORD_WIDTH-1:0] x2;
	logic signed [COORD_WIDTH-1:0] y2;

	modport source (output valid, x0, y0, x1, y1, x2, y2, input ready);
	modport sink (input valid, x0, y0, x1, y1, x2, y2, output ready);
endinterface

interface tes_out_if #(
	parameter int RESULT_WIDTH = 32
) ();
	logic                           valid;
	logic                           ready;
	logic signed [RESULT_WIDTH-1:0] k00;
	logic signed [RESULT_WIDTH-1:0] k11;
	logic signed [RESULT_WIDTH-1:0] k22;
	logic signed [RESULT_WIDTH-1:0] k01;
	logic signed [RESULT_WIDTH-1:0] k12;
	logic signed [RESULT_WIDTH-1:0] k20;
	logic                           degenerate;

	modport source (output valid, k00, k11, k22, k01, k12, k20, degenerate, input ready);
	modport sink (input valid, k00, k11, k22, k01, k12, k20, degenerate, output ready);
endinterface

// ----- rtl/core/tes_prep.sv -----
// ----------------------------------------------------------------------------
// tes_prep
// Four stages: gradient numerators, products, sums, magnitudes and signs.
// ----------------------------------------------------------------------------
module tes_prep #(
	parameter int COORD_WIDTH = 18
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic signed [COORD_WIDTH-1:0] x [tes_pkg::NUM_CORNERS],
	input  logic signed [COORD_WIDTH-1:0] y [tes_pkg::NUM_CORNERS],
	output tes_pkg::ctl_t                 ctl,
	output logic [2*COORD_WIDTH+3:0]      dd,
	output logic [2*COORD_WIDTH+2:0]      nmag [tes_pkg::NUM_K],
	output logic                          neg [tes_pkg::NUM_K]
);
	localparam int DW = COORD_WIDTH + 1;
	localparam int PW = 2 * DW;
	localparam int MW = PW + 1;

	logic                 v_s1, v_s2, v_s3, v_s4;
	logic signed [DW-1:0] b_s1 [tes_pkg::NUM_CORNERS];
	logic signed [DW-1:0] c_s1 [tes_pkg::NUM_CORNERS];
	logic signed [PW-1:0] bb_s2 [tes_pkg::NUM_K];
	logic signed [PW-1:0] cc_s2 [tes_pkg::NUM_K];
	logic signed [PW-1:0] da_s2, db_s2;
	logic signed [PW:0]   den_s3;
	logic signed [PW:0]   num_s3 [tes_pkg::NUM_K];
	logic                 degen_s4;
	logic [MW-1:0]        den_mag;
	logic [MW-1:0]        dmag_s4;
	logic [MW-1:0]        nmag_s4 [tes_pkg::NUM_K];
	logic                 neg_s4 [tes_pkg::NUM_K];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign den_mag = den_s3[PW] ? MW'(-den_s3) : MW'(den_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			b_s1[0] <= DW'(y[1]) - DW'(y[2]);
			b_s1[1] <= DW'(y[2]) - DW'(y[0]);
			b_s1[2] <= DW'(y[0]) - DW'(y[1]);
			c_s1[0] <= DW'(x[2]) - DW'(x[1]);
			c_s1[1] <= DW'(x[0]) - DW'(x[2]);
			c_s1[2] <= DW'(x[1]) - DW'(x[0]);

			da_s2 <= PW'(c_s1[2]) * PW'(b_s1[1]);
			db_s2 <= PW'(c_s1[1]) * PW'(b_s1[2]);
			for (int i = 0; i < tes_pkg::NUM_K; i++) begin
				bb_s2[i] <= PW'(b_s1[tes_pkg::PAIR_A[i]]) * PW'(b_s1[tes_pkg::PAIR_B[i]]);
				cc_s2[i] <= PW'(c_s1[tes_pkg::PAIR_A[i]]) * PW'(c_s1[tes_pkg::PAIR_B[i]]);
			end

			den_s3 <= (PW+1)'(da_s2) - (PW+1)'(db_s2);
			for (int i = 0; i < tes_pkg::NUM_K; i++) begin
				num_s3[i] <= (PW+1)'(bb_s2[i]) + (PW+1)'(cc_s2[i]);
			end

			degen_s4 <= (den_s3 == '0);
			dmag_s4  <= den_mag;
			for (int i = 0; i < tes_pkg::NUM_K; i++) begin
				neg_s4[i]  <= num_s3[i][PW];
				nmag_s4[i] <= num_s3[i][PW] ? MW'(-num_s3[i]) : MW'(num_s3[i]);
			end
		end
	end

	assign ctl.valid = v_s4;
	assign ctl.degen = degen_s4;
	assign dd        = {dmag_s4, 1'b0};
	assign nmag      = nmag_s4;
	assign neg       = neg_s4;

endmodule

// ----- rtl/core/tes_div.sv -----
// ----------------------------------------------------------------------------
// tes_div
// Six restoring divider lanes, one quotient bit per stage, with an overflow
// check ahead of the first bit and saturation after the last.
// ----------------------------------------------------------------------------
module tes_div #(
	parameter int COORD_WIDTH  = 18,
	parameter int RESULT_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  tes_pkg::ctl_t                  ctl_in,
	input  logic [2*COORD_WIDTH+3:0]       dd_in,
	input  logic [2*COORD_WIDTH+2:0]       nmag_in [tes_pkg::NUM_K],
	input  logic                           neg_in [tes_pkg::NUM_K],
	output tes_pkg::ctl_t                  ctl_out,
	output logic signed [RESULT_WIDTH-1:0] k_out [tes_pkg::NUM_K]
);
	localparam int RW  = RESULT_WIDTH;
	localparam int MW  = 2 * COORD_WIDTH + 3;
	localparam int DDW = MW + 1;
	localparam int RMW = DDW + RW;

	localparam logic [RW-1:0] MAXV = {1'b0, {(RW-1){1'b1}}};
	localparam logic [RW-1:0] MINV = {1'b1, {(RW-1){1'b0}}};

	tes_pkg::ctl_t  ctl_s  [RW+1];
	logic [DDW-1:0] dd_s   [RW+1];
	logic [RMW-1:0] rem_s  [RW+1][tes_pkg::NUM_K];
	logic [RW-1:0]  quo_s  [RW+1][tes_pkg::NUM_K];
	logic           neg_s  [RW+1][tes_pkg::NUM_K];
	logic           ovf_s  [RW+1][tes_pkg::NUM_K];
	logic [RMW:0]   trial  [RW][tes_pkg::NUM_K];
	logic [RMW-1:0] dvd    [tes_pkg::NUM_K];
	logic [RMW-1:0] lim;

	always_comb begin
		lim = {dd_in, {RW{1'b0}}};
		for (int l = 0; l < tes_pkg::NUM_K; l++) begin
			dvd[l] = RMW'({nmag_in[l], {tes_pkg::FRAC_BITS{1'b0}}});
		end
	end

	always_comb begin
		logic [RMW-1:0] shifted;
		shifted = '0;
		for (int j = 1; j <= RW; j++) begin
			shifted = RMW'(dd_s[j-1]) << (RW - j);
			for (int l = 0; l < tes_pkg::NUM_K; l++) begin
				trial[j-1][l] = {1'b0, rem_s[j-1][l]} - {1'b0, shifted};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= RW; j++) begin
				ctl_s[j] <= '0;
			end
		end else if (en) begin
			ctl_s[0] <= ctl_in;
			for (int j = 1; j <= RW; j++) begin
				ctl_s[j] <= ctl_s[j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dd_s[0] <= dd_in;
			for (int l = 0; l < tes_pkg::NUM_K; l++) begin
				rem_s[0][l] <= dvd[l];
				quo_s[0][l] <= '0;
				neg_s[0][l] <= neg_in[l];
				ovf_s[0][l] <= (dvd[l] >= lim);
			end
			for (int j = 1; j <= RW; j++) begin
				dd_s[j] <= dd_s[j-1];
				for (int l = 0; l < tes_pkg::NUM_K; l++) begin
					rem_s[j][l] <= trial[j-1][l][RMW] ? rem_s[j-1][l] : trial[j-1][l][RMW-1:0];
					quo_s[j][l] <= {quo_s[j-1][l][RW-2:0], ~trial[j-1][l][RMW]};
					neg_s[j][l] <= neg_s[j-1][l];
					ovf_s[j][l] <= ovf_s[j-1][l];
				end
			end
		end
	end

	always_comb begin
		logic [RW-1:0] q;
		q = '0;
		for (int l = 0; l < tes_pkg::NUM_K; l++) begin
			q = quo_s[RW][l];
			if (ctl_s[RW].degen) begin
				k_out[l] = '0;
			end else if (neg_s[RW][l]) begin
				if (ovf_s[RW][l] || (q[RW-1] && (q[RW-2:0] != '0))) begin
					k_out[l] = $signed(MINV);
				end else begin
					k_out[l] = $signed(-q);
				end
			end else begin
				if (ovf_s[RW][l] || q[RW-1]) begin
					k_out[l] = $signed(MAXV);
				end else begin
					k_out[l] = $signed(q);
				end
			end
		end
	end

	assign ctl_out = ctl_s[RW];

endmodule

// ----- rtl/core/tes_skid.sv -----
// ----------------------------------------------------------------------------
// tes_skid
// Output register with a skid word; the pipeline advance is registered.
// ----------------------------------------------------------------------------
module tes_skid #(
	parameter int RESULT_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tes_pkg::ctl_t                  ctl_in,
	input  logic signed [RESULT_WIDTH-1:0] k_in [tes_pkg::NUM_K],
	input  logic                           out_ready,
	output logic                           en,
	output tes_pkg::ctl_t                  ctl_out,
	output logic signed [RESULT_WIDTH-1:0] k_out [tes_pkg::NUM_K]
);
	logic                           out_v_q, sk_v_q;
	logic                           out_dg_q, sk_dg_q;
	logic signed [RESULT_WIDTH-1:0] out_k_q [tes_pkg::NUM_K];
	logic signed [RESULT_WIDTH-1:0] sk_k_q [tes_pkg::NUM_K];
	logic                           arrive;
	logic                           load;

	assign en     = ~sk_v_q;
	assign arrive = ctl_in.valid & ~sk_v_q;
	assign load   = ~out_v_q | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			sk_v_q  <= 1'b0;
		end else if (load) begin
			out_v_q <= sk_v_q | arrive;
			sk_v_q  <= 1'b0;
		end else if (arrive) begin
			sk_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (sk_v_q) begin
				out_dg_q <= sk_dg_q;
				out_k_q  <= sk_k_q;
			end else begin
				out_dg_q <= ctl_in.degen;
				out_k_q  <= k_in;
			end
		end else if (arrive) begin
			sk_dg_q <= ctl_in.degen;
			sk_k_q  <= k_in;
		end
	end

	assign ctl_out.valid = out_v_q;
	assign ctl_out.degen = out_dg_q;
	assign k_out         = out_k_q;

endmodule

// ----- rtl/core/triangle_element_stiffness.sv -----
// ----------------------------------------------------------------------------
// triangle_element_stiffness
// Linear triangle element: six local stiffness entries per triangle.
// ----------------------------------------------------------------------------
// Takes one triangle per clock while corners.ready is high and returns its six
// Q16.16 stiffness entries (truncated toward zero, saturated). Behind four
// stages of differences, products, sums and magnitudes and one overflow check
// stage, six restoring divider lanes resolve one quotient bit per pipeline
// stage. The output has a two-word buffer: a stalled output drops
// corners.ready once a word lands in the skid register, and no word is lost
// while the pipeline holds.
module triangle_element_stiffness #(
	parameter int COORD_WIDTH  = 18,
	parameter int RESULT_WIDTH = 32
) (
	input logic        clk,
	input logic        arst_n,
	tes_in_if.sink     corners,
	tes_out_if.source  entries
);
	logic                           en;
	logic signed [COORD_WIDTH-1:0]  xs [tes_pkg::NUM_CORNERS];
	logic signed [COORD_WIDTH-1:0]  ys [tes_pkg::NUM_CORNERS];
	tes_pkg::ctl_t                  prep_ctl, div_ctl, out_ctl;
	logic [2*COORD_WIDTH+3:0]       dd;
	logic [2*COORD_WIDTH+2:0]       nmag [tes_pkg::NUM_K];
	logic                           neg [tes_pkg::NUM_K];
	logic signed [RESULT_WIDTH-1:0] div_k [tes_pkg::NUM_K];
	logic signed [RESULT_WIDTH-1:0] out_k [tes_pkg::NUM_K];

	assign xs[0] = corners.x0;
	assign ys[0] = corners.y0;
	assign xs[1] = corners.x1;
	assign ys[1] = corners.y1;
	assign xs[2] = corners.x2;
	assign ys[2] = corners.y2;

	assign corners.ready = en;

	tes_prep #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (corners.valid),
		.x        (xs),
		.y        (ys),
		.ctl      (prep_ctl),
		.dd       (dd),
		.nmag     (nmag),
		.neg      (neg)
	);

	tes_div #(
		.COORD_WIDTH  (COORD_WIDTH),
		.RESULT_WIDTH (RESULT_WIDTH)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_in  (prep_ctl),
		.dd_in   (dd),
		.nmag_in (nmag),
		.neg_in  (neg),
		.ctl_out (div_ctl),
		.k_out   (div_k)
	);

	tes_skid #(
		.RESULT_WIDTH (RESULT_WIDTH)
	) u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_in    (div_ctl),
		.k_in      (div_k),
		.out_ready (entries.ready),
		.en        (en),
		.ctl_out   (out_ctl),
		.k_out     (out_k)
	);

	assign entries.valid      = out_ctl.valid;
	assign entries.degenerate = out_ctl.degen;
	assign entries.k00        = out_k[0];
	assign entries.k11        = out_k[1];
	assign entries.k22        = out_k[2];
	assign entries.k01        = out_k[3];
	assign entries.k12        = out_k[4];
	assign entries.k20        = out_k[5];

endmodule

// ----- rtl/core/tes_checker.sv -----
// ----------------------------------------------------------------------------
// tes_checker
// Port-level checks on the stiffness block, bound to the top level.
// ----------------------------------------------------------------------------
module tes_checker #(
	parameter int RESULT_WIDTH = 32
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [RESULT_WIDTH-1:0] k00,
	input logic [RESULT_WIDTH-1:0] k11,
	input logic [RESULT_WIDTH-1:0] k22,
	input logic [RESULT_WIDTH-1:0] k01,
	input logic [RESULT_WIDTH-1:0] k12,
	input logic [RESULT_WIDTH-1:0] k20,
	input logic                    degenerate
);
	logic stall;

	assign stall = out_valid & ~out_ready;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> out_valid && $stable(k00) && $stable(k11) && $stable(k22)
			&& $stable(k01) && $stable(k12) && $stable(k20) && $stable(degenerate))
		else $error("stalled output word changed");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> k00 == '0 && k11 == '0 && k22 == '0
			&& k01 == '0 && k12 == '0 && k20 == '0)
		else $error("degenerate triangle with nonzero entries");

	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(stall))
		else $error("input ready dropped without an output stall");

	a_first_stall: assert property (@(posedge clk) disable iff (!arst_n)
		stall && !$past(stall) |-> in_ready)
		else $error("input not accepted on first cycle of an output stall");

endmodule

bind triangle_element_stiffness tes_checker #(
	.RESULT_WIDTH (RESULT_WIDTH)
) u_tes_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (corners.ready),
	.out_valid  (entries.valid),
	.out_ready  (entries.ready),
	.k00        (entries.k00),
	.k11        (entries.k11),
	.k22        (entries.k22),
	.k01        (entries.k01),
	.k12        (entries.k12),
	.k20        (entries.k20),
	.degenerate (entries.degenerate)
);

// ----- tb/tb_triangle_element_stiffness.sv -----
// ----------------------------------------------------------------------------
// tb_triangle_element_stiffness
// Self-checking bench for the linear triangle element stiffness pipeline.
// ----------------------------------------------------------------------------
// Streams triangles into the corner channel and checks every stiffness word
// against an in-bench computation of the six entries, in order. Directed
// triangles cover the coordinate extremes, zero-area cases, saturation and
// orientation. Random triangles follow: general, small local, thin, collinear
// and flipped shapes. Both channels idle at random, and the sender drains
// the pipeline between tests.
// ----------------------------------------------------------------------------
module tb_triangle_element_stiffness;

	localparam int COORD_W     = 18;
	localparam int RESULT_W    = 32;
	localparam int IDLE_LIMIT  = 4000;
	localparam int TAIL_CYCLES = RESULT_W + 30;
	localparam int REPORT_MAX  = 10;

	typedef logic signed [COORD_W-1:0]  coord_t;
	typedef logic signed [RESULT_W-1:0] entry_t;

	typedef struct {
		coord_t x0, y0, x1, y1, x2, y2;
	} triangle_t;

	typedef struct {
		entry_t k [tes_pkg::NUM_K];
		logic   degenerate;
	} stiffness_t;

	localparam string K_NAME [tes_pkg::NUM_K] = '{"k00", "k11", "k22", "k01", "k12", "k20"};

	typedef enum int {
		SHAPE_GENERAL,
		SHAPE_LOCAL,
		SHAPE_THIN,
		SHAPE_COLLINEAR,
		SHAPE_FLIPPED
	} shape_t;

	logic clk = 1'b0;
	logic arst_n;

	tes_in_if  #(.COORD_WIDTH(COORD_W))   corners ();
	tes_out_if #(.RESULT_WIDTH(RESULT_W)) entries ();

	triangle_element_stiffness #(
		.COORD_WIDTH  (COORD_W),
		.RESULT_WIDTH (RESULT_W)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.corners (corners),
		.entries (entries)
	);

	stiffness_t pending_stiffness [$];
	int         failures = 0;
	int         tx_quiet = 0;
	int         rx_quiet = 0;
	int         idle_cycles = 0;

	always #10 clk = ~clk;

	function automatic int pick_gap(inout int quiet);
		int roll;
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		roll = $urandom_range(0, 999);
		if (roll < 15) begin
			quiet = $urandom_range(30, 120);
			return 0;
		end
		if (roll < 600)
			return 0;
		if (roll < 900)
			return $urandom_range(1, 3);
		if (roll < 985)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic stiffness_t predict_stiffness(triangle_t t);
		longint x [3];
		longint y [3];
		longint b [3];
		longint c [3];
		longint den, dd, num, mag, q, maxpos;
		stiffness_t r;
		x[0] = t.x0; y[0] = t.y0;
		x[1] = t.x1; y[1] = t.y1;
		x[2] = t.x2; y[2] = t.y2;
		for (int i = 0; i < tes_pkg::NUM_CORNERS; i++) begin
			b[i] = y[(i + 1) % 3] - y[(i + 2) % 3];
			c[i] = x[(i + 2) % 3] - x[(i + 1) % 3];
		end
		den = (x[1] - x[0]) * (y[2] - y[0]) - (x[2] - x[0]) * (y[1] - y[0]);
		for (int i = 0; i < tes_pkg::NUM_K; i++)
			r.k[i] = '0;
		r.degenerate = 1'b0;
		if (den == 0) begin
			r.degenerate = 1'b1;
			return r;
		end
		dd = 2 * ((den < 0) ? -den : den);
		maxpos = (longint'(1) <<< (RESULT_W - 1)) - 1;
		for (int i = 0; i < tes_pkg::NUM_K; i++) begin
			num = b[tes_pkg::PAIR_A[i]] * b[tes_pkg::PAIR_B[i]]
			    + c[tes_pkg::PAIR_A[i]] * c[tes_pkg::PAIR_B[i]];
			mag = (num < 0) ? -num : num;
			q = (mag <<< tes_pkg::FRAC_BITS) / dd;
			if (num < 0) begin
				if (q > maxpos + 1)
					q = maxpos + 1;
				q = -q;
			end else if (q > maxpos) begin
				q = maxpos;
			end
			r.k[i] = q[RESULT_W-1:0];
		end
		return r;
	endfunction

	function automatic triangle_t triangle(coord_t x0, coord_t y0, coord_t x1, coord_t y1,
	                                       coord_t x2, coord_t y2);
		triangle_t t;
		t.x0 = x0; t.y0 = y0;
		t.x1 = x1; t.y1 = y1;
		t.x2 = x2; t.y2 = y2;
		return t;
	endfunction

	function automatic coord_t rand_coord();
		return coord_t'($urandom);
	endfunction

	function automatic coord_t near(coord_t base, int spread);
		return coord_t'(int'(base) + $urandom_range(0, 2 * spread) - spread);
	endfunction

	function automatic triangle_t make_triangle(shape_t shape);
		triangle_t t;
		coord_t    dx, dy;
		int        spread;
		case (shape)
			SHAPE_LOCAL: begin
				spread = 1 << $urandom_range(2, 14);
				t.x0 = rand_coord();
				t.y0 = rand_coord();
				t.x1 = near(t.x0, spread);
				t.y1 = near(t.y0, spread);
				t.x2 = near(t.x0, spread);
				t.y2 = near(t.y0, spread);
			end
			SHAPE_THIN: begin
				t = triangle(rand_coord(), rand_coord(), rand_coord(), '0,
				             rand_coord(), '0);
				t.y1 = t.y0;
				t.y2 = near(t.y0, 3);
				if ($urandom_range(0, 1)) begin
					t = triangle(t.y0, t.x0, t.y1, t.x1, t.y2, t.x2);
				end
			end
			SHAPE_COLLINEAR: begin
				t = triangle(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
				             rand_coord(), rand_coord());
				case ($urandom_range(0, 3))
					0: begin
						t.x2 = t.x0;
						t.y2 = t.y0;
					end
					1: begin
						t.x1 = t.x0;
						t.x2 = t.x0;
					end
					2: begin
						t.y1 = t.y0;
						t.y2 = t.y0;
					end
					default: begin
						dx = coord_t'($urandom_range(0, 40000) - 20000);
						dy = coord_t'($urandom_range(0, 40000) - 20000);
						t.x0 = near('0, 40000);
						t.y0 = near('0, 40000);
						t.x1 = t.x0 + dx;
						t.y1 = t.y0 + dy;
						t.x2 = t.x1 + dx;
						t.y2 = t.y1 + dy;
					end
				endcase
			end
			SHAPE_FLIPPED: begin
				t = make_triangle(SHAPE_LOCAL);
				t = triangle(t.x1, t.y1, t.x0, t.y0, t.x2, t.y2);
			end
			default: begin
				t = triangle(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
				             rand_coord(), rand_coord());
			end
		endcase
		return t;
	endfunction

	task automatic send_triangle(triangle_t t);
		int gap;
		gap = pick_gap(tx_quiet);
		if (gap > 0) begin
			corners.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		corners.valid <= 1'b1;
		corners.x0    <= t.x0;
		corners.y0    <= t.y0;
		corners.x1    <= t.x1;
		corners.y1    <= t.y1;
		corners.x2    <= t.x2;
		corners.y2    <= t.y2;
		@(posedge clk);
		while (!corners.ready)
			@(posedge clk);
		pending_stiffness.push_back(predict_stiffness(t));
	endtask

	task automatic wait_drained();
		corners.valid <= 1'b0;
		while (pending_stiffness.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_corner_extremes();
		coord_t lo, hi;
		lo = {1'b1, {(COORD_W-1){1'b0}}};
		hi = {1'b0, {(COORD_W-1){1'b1}}};
		send_triangle(triangle(lo, lo, hi, lo, lo, hi));
		send_triangle(triangle(hi, hi, lo, hi, hi, lo));
		send_triangle(triangle(lo, hi, hi, lo, hi, hi));
		send_triangle(triangle(lo, lo, hi, hi, lo, hi));
		send_triangle(triangle('0, '0, 18'sd1, '0, '0, 18'sd1));
		send_triangle(triangle('0, '0, 18'sd65536, '0, '0, 18'sd65536));
		send_triangle(triangle('0, '0, 18'sd65536, '0, 18'sd32768, 18'sd56756));
		send_triangle(triangle(-18'sd1, -18'sd1, '0, -18'sd1, -18'sd1, '0));
	endtask

	task automatic test_degenerate();
		coord_t lo, hi;
		lo = {1'b1, {(COORD_W-1){1'b0}}};
		hi = {1'b0, {(COORD_W-1){1'b1}}};
		send_triangle(triangle('0, '0, '0, '0, '0, '0));
		send_triangle(triangle(hi, lo, hi, lo, hi, lo));
		send_triangle(triangle(lo, lo, '0, '0, hi, hi));
		send_triangle(triangle(lo, '0, hi, '0, 18'sd5, '0));
		send_triangle(triangle(18'sd100, 18'sd7, 18'sd100, 18'sd7, lo, hi));
	endtask

	task automatic test_saturation();
		coord_t lo, hi;
		lo = {1'b1, {(COORD_W-1){1'b0}}};
		hi = {1'b0, {(COORD_W-1){1'b1}}};
		send_triangle(triangle('0, '0, hi, '0, lo, 18'sd1));
		send_triangle(triangle(lo, lo, hi, hi, hi, hi - 18'sd1));
		send_triangle(triangle(lo, '0, hi, '0, '0, 18'sd1));
		send_triangle(triangle('0, lo, '0, hi, 18'sd1, hi));
	endtask

	task automatic test_orientation();
		send_triangle(triangle(18'sd1000, 18'sd2000, 18'sd70000, -18'sd3000,
		                       -18'sd5000, 18'sd90000));
		send_triangle(triangle(18'sd70000, -18'sd3000, 18'sd1000, 18'sd2000,
		                       -18'sd5000, 18'sd90000));
		send_triangle(triangle(-18'sd40000, 18'sd12, 18'sd33, 18'sd60000,
		                       18'sd1, -18'sd9));
		send_triangle(triangle(-18'sd40000, 18'sd12, 18'sd1, -18'sd9,
		                       18'sd33, 18'sd60000));
	endtask

	task automatic test_random_mesh(int count);
		int     roll;
		shape_t shape;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 40)
				shape = SHAPE_GENERAL;
			else if (roll < 65)
				shape = SHAPE_LOCAL;
			else if (roll < 77)
				shape = SHAPE_THIN;
			else if (roll < 89)
				shape = SHAPE_COLLINEAR;
			else
				shape = SHAPE_FLIPPED;
			send_triangle(make_triangle(shape));
			if ($urandom_range(0, 399) == 0)
				wait_drained();
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		corners.valid = 1'b0;
		corners.x0    = '0;
		corners.y0    = '0;
		corners.x1    = '0;
		corners.y1    = '0;
		corners.x2    = '0;
		corners.y2    = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_extremes();
		wait_drained();
		test_degenerate();
		wait_drained();
		test_saturation();
		wait_drained();
		test_orientation();
		wait_drained();
		test_random_mesh(1830);
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (failures == 0 && pending_stiffness.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		int         stall_left;
		stiffness_t want;
		stiffness_t got;
		stall_left    = 0;
		entries.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && entries.valid && entries.ready) begin
				got.k[0]       = entries.k00;
				got.k[1]       = entries.k11;
				got.k[2]       = entries.k22;
				got.k[3]       = entries.k01;
				got.k[4]       = entries.k12;
				got.k[5]       = entries.k20;
				got.degenerate = entries.degenerate;
				if (pending_stiffness.size() == 0) begin
					failures++;
					if (failures <= REPORT_MAX)
						$display("unexpected stiffness word at %0t", $realtime);
				end else begin
					want = pending_stiffness.pop_front();
					for (int i = 0; i < tes_pkg::NUM_K; i++) begin
						if (got.k[i] !== want.k[i]) begin
							failures++;
							if (failures <= REPORT_MAX)
								$display("mismatch %s: expected %0d, actual %0d",
								         K_NAME[i], want.k[i], got.k[i]);
						end
					end
					if (got.degenerate !== want.degenerate) begin
						failures++;
						if (failures <= REPORT_MAX)
							$display("mismatch degenerate: expected %0b, actual %0b",
							         want.degenerate, got.degenerate);
					end
				end
			end
			if (stall_left > 0) begin
				entries.ready <= 1'b0;
				stall_left--;
			end else begin
				entries.ready <= 1'b1;
				stall_left = pick_gap(rx_quiet);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((corners.valid && corners.ready) || (entries.valid && entries.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

endmodule
